[rtl/core/positional_list_store_core_assert.svh]
// ----------------------------------------------------------------------------
// positional_list_store_core_assert.svh
// Assertion macros used by the list store checker, plsc_chk.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_CORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define PLSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define PLSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/plsc_pkg.sv]
// ----------------------------------------------------------------------------
// plsc_pkg
// Sizes, codes, control structs and helpers for the positional list store.
// ----------------------------------------------------------------------------
package plsc_pkg;

  localparam int CAPACITY   = 32;
  localparam int DATA_WIDTH = 32;

  localparam int OP_W    = 3;
  localparam int FIELD_W = 32;
  localparam int POS_W   = 16;
  localparam int ST_W    = 2;
  localparam int EIDX_W  = 5;
  localparam int LEN_W   = 6;

  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int DUMP_MAX = (CAPACITY < 32) ? CAPACITY : 32;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FIRST,
    OP_INS_LAST,
    OP_INS_AT,
    OP_DEL_FIRST,
    OP_DEL_LAST,
    OP_DEL_AT,
    OP_DUMP,
    OP_CLEAR
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK,
    ST_EMPTY,
    ST_FULL,
    ST_RANGE
  } status_t;

  typedef struct packed {
    logic exec;       // request accepted, execute it now
    logic dump_step;  // load the next dump result
  } plsc_cmd_t;

  typedef struct packed {
    logic dump_more;  // accepted dump has more than one result
    logic dump_last;  // pending dump result is the final one
  } plsc_sts_t;

  // input value to stored width (sign-extend or truncate)
  function automatic logic [DATA_WIDTH-1:0] to_store(input logic [FIELD_W-1:0] v);
    logic [DATA_WIDTH+FIELD_W-1:0] ext;
    ext = {{DATA_WIDTH{v[FIELD_W-1]}}, v};
    return ext[DATA_WIDTH-1:0];
  endfunction

  // stored value back to field width
  function automatic logic [FIELD_W-1:0] to_field(input logic [DATA_WIDTH-1:0] v);
    logic [DATA_WIDTH+FIELD_W-1:0] ext;
    ext = {{FIELD_W{v[DATA_WIDTH-1]}}, v};
    return ext[FIELD_W-1:0];
  endfunction

  function automatic logic [EIDX_W-1:0] to_eidx(input logic [CNT_W-1:0] v);
    logic [CNT_W+EIDX_W-1:0] ext;
    ext = {{EIDX_W{1'b0}}, v};
    return ext[EIDX_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] to_len(input logic [CNT_W-1:0] v);
    logic [CNT_W+LEN_W-1:0] ext;
    ext = {{LEN_W{1'b0}}, v};
    return ext[LEN_W-1:0];
  endfunction

endpackage

[rtl/core/positional_list_store_core.sv]
// ----------------------------------------------------------------------------
// positional_list_store_core
// Bounded ordered list of signed values with positional insert and delete.
// ----------------------------------------------------------------------------
// Use of the block:
//   Input channel (in_valid / in_stall) carries one request: opcode, value
//   and a one-based position. Result channel (out_valid / out_stall) carries
//   status, data, element index, length after the operation and a last flag.
//   Every request gives one result, except a dump of a non-empty list, which
//   gives one result per entry (up to 32) in list order, last flag on the
//   final one.
//   The result is registered and appears in the cycle after the request is
//   accepted. Insert, delete and clear finish when accepted, so a request
//   can be accepted every cycle while results drain. A dump holds the input
//   until its last result is loaded, reading one entry per cycle while the
//   result side does not stall, through the single entry read port of the
//   shifting store. Inserts and deletes move every entry above the addressed
//   slot together; the list never has gaps.
//   A stall on the result side holds the result register; the next request
//   is taken only once the held result is taken in the same cycle.
//   Reset (rst_n low, synchronous) empties the list and drops any pending
//   result; stored entries are not cleared and never read before written.
// ----------------------------------------------------------------------------
module positional_list_store_core import plsc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  // request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [OP_W-1:0]           in_opcode,
  input  logic signed [FIELD_W-1:0] in_value,
  input  logic signed [POS_W-1:0]   in_position,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ST_W-1:0]           out_status,
  output logic signed [FIELD_W-1:0] out_data_out,
  output logic [EIDX_W-1:0]         out_element_index,
  output logic [LEN_W-1:0]          out_length,
  output logic                      out_last
);

  plsc_cmd_t cmd;  // controller to datapath
  plsc_sts_t sts;  // datapath to controller

  // handshakes and dump sequencing
  plsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // entry store, count and result register
  plsc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_opcode         (in_opcode),
    .in_value          (in_value),
    .in_position       (in_position),
    .cmd               (cmd),
    .sts               (sts),
    .out_status        (out_status),
    .out_data_out      (out_data_out),
    .out_element_index (out_element_index),
    .out_length        (out_length),
    .out_last          (out_last)
  );

endmodule

[rtl/core/plsc_ctrl.sv]
// ----------------------------------------------------------------------------
// plsc_ctrl
// Handshake controller: accepts requests, sequences dump results.
// ----------------------------------------------------------------------------
module plsc_ctrl import plsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output plsc_cmd_t cmd,
  input  plsc_sts_t sts
);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // output register can take a new result this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = !out_free;
        if (out_free && in_valid) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          if (sts.dump_more) begin
            state_nxt = S_DUMP;
          end
        end
      end
      S_DUMP: begin
        if (out_free) begin
          cmd.dump_step = 1'b1;
          out_valid_nxt = 1'b1;
          if (sts.dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/core/plsc_dp.sv]
// ----------------------------------------------------------------------------
// plsc_dp
// Datapath: shifting entry store, count, dump index and result register.
// ----------------------------------------------------------------------------
module plsc_dp import plsc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [OP_W-1:0]           in_opcode,
  input  logic signed [FIELD_W-1:0] in_value,
  input  logic signed [POS_W-1:0]   in_position,
  input  plsc_cmd_t                 cmd,
  output plsc_sts_t                 sts,
  output logic [ST_W-1:0]           out_status,
  output logic signed [FIELD_W-1:0] out_data_out,
  output logic [EIDX_W-1:0]         out_element_index,
  output logic [LEN_W-1:0]          out_length,
  output logic                      out_last
);

  logic [DATA_WIDTH-1:0] ent_r    [CAPACITY];
  logic [DATA_WIDTH-1:0] ent_nxt  [CAPACITY];
  logic [DATA_WIDTH-1:0] ent_up   [CAPACITY];  // entry i-1 (new value at 0)
  logic [DATA_WIDTH-1:0] ent_down [CAPACITY];  // entry i+1

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  dump_idx_r;
  logic [ST_W-1:0]   status_r;
  logic [FIELD_W-1:0] data_r;
  logic [EIDX_W-1:0] eidx_r;
  logic [LEN_W-1:0]  len_r;
  logic              last_r;

  op_t                   op;
  logic [DATA_WIDTH-1:0] wr_val;
  logic [POS_W-1:0]      pidx;
  logic [POS_W-1:0]      cnt_ext;
  logic [CNT_W-1:0]      ins_idx;
  logic [POS_W-1:0]      del_idx;
  logic [CNT_W-1:0]      dump_n;
  logic [IDX_W-1:0]      rd_addr;
  logic [FIELD_W-1:0]    rd_data;
  logic                  do_ins, do_del;

  logic [ST_W-1:0]    res_status;
  logic [FIELD_W-1:0] res_data;
  logic [EIDX_W-1:0]  res_eidx;

  assign op      = op_t'(in_opcode);
  assign wr_val  = to_store(in_value);
  assign cnt_ext = POS_W'(count_r);
  assign pidx    = (in_position <= $signed(POS_W'(1))) ? '0 : in_position - POS_W'(1);
  assign dump_n  = (count_r > CNT_W'(DUMP_MAX)) ? CNT_W'(DUMP_MAX) : count_r;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_ent
    if (g == 0) begin : g_first
      assign ent_up[g] = wr_val;
    end else begin : g_rest
      assign ent_up[g] = ent_r[g-1];
    end
    if (g == CAPACITY - 1) begin : g_top
      assign ent_down[g] = ent_r[g];
    end else begin : g_below
      assign ent_down[g] = ent_r[g+1];
    end
  end

  // slot addressed by each operation
  always_comb begin
    ins_idx = '0;
    del_idx = '0;
    unique case (op)
      OP_INS_FIRST: ins_idx = '0;
      OP_INS_LAST:  ins_idx = count_r;
      OP_INS_AT:    ins_idx = (pidx > cnt_ext) ? count_r : CNT_W'(pidx);
      OP_DEL_FIRST: del_idx = '0;
      OP_DEL_LAST:  del_idx = cnt_ext - POS_W'(1);
      OP_DEL_AT:    del_idx = pidx;
      OP_DUMP:      del_idx = '0;
      OP_CLEAR:     del_idx = '0;
    endcase
  end

  assign rd_addr = cmd.exec ? del_idx[IDX_W-1:0] : dump_idx_r;
  assign rd_data = to_field(ent_r[rd_addr]);

  // result and count for an accepted request
  always_comb begin
    do_ins     = 1'b0;
    do_del     = 1'b0;
    count_nxt  = count_r;
    res_status = ST_OK;
    res_data   = '0;
    res_eidx   = '0;
    unique case (op)
      OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
        if (count_r == CNT_W'(CAPACITY)) begin
          res_status = ST_FULL;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          res_eidx  = to_eidx(ins_idx);
        end
      end
      OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
        if (count_r == '0) begin
          res_status = ST_EMPTY;
        end else if (del_idx >= cnt_ext) begin
          res_status = ST_RANGE;
        end else begin
          do_del    = 1'b1;
          count_nxt = count_r - CNT_W'(1);
          res_data  = rd_data;
          res_eidx  = to_eidx(CNT_W'(del_idx));
        end
      end
      OP_DUMP: begin
        if (count_r == '0) begin
          res_status = ST_EMPTY;
        end else begin
          res_data = rd_data;
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ent_nxt[i] = ent_r[i];
      if (do_ins) begin
        if (CNT_W'(i) == ins_idx) begin
          ent_nxt[i] = wr_val;
        end else if (CNT_W'(i) > ins_idx) begin
          ent_nxt[i] = ent_up[i];
        end
      end else if (do_del) begin
        if (POS_W'(i) >= del_idx) begin
          ent_nxt[i] = ent_down[i];
        end
      end
    end
  end

  assign sts.dump_more = (op == OP_DUMP) && (dump_n > CNT_W'(1));
  assign sts.dump_last = ((IDX_W+1)'(dump_idx_r) + (IDX_W+1)'(1)) == (IDX_W+1)'(dump_n);

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ent_r <= ent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      dump_idx_r <= '0;
    end else if (cmd.exec) begin
      count_r    <= count_nxt;
      dump_idx_r <= IDX_W'(1);
    end else if (cmd.dump_step) begin
      dump_idx_r <= dump_idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= res_status;
      data_r   <= res_data;
      eidx_r   <= res_eidx;
      len_r    <= to_len(count_nxt);
      last_r   <= !sts.dump_more;
    end else if (cmd.dump_step) begin
      status_r <= ST_OK;
      data_r   <= rd_data;
      eidx_r   <= to_eidx(CNT_W'(dump_idx_r));
      len_r    <= to_len(count_r);
      last_r   <= sts.dump_last;
    end
  end

  assign out_status        = status_r;
  assign out_data_out      = data_r;
  assign out_element_index = eidx_r;
  assign out_length        = len_r;
  assign out_last          = last_r;

endmodule

[rtl/core/plsc_chk.sv]
// ----------------------------------------------------------------------------
// plsc_chk
// Port-level checker for the positional list store, bound to the top level.
// ----------------------------------------------------------------------------
`include "positional_list_store_core_assert.svh"

module plsc_chk import plsc_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [ST_W-1:0]           out_status,
  input logic signed [FIELD_W-1:0] out_data_out,
  input logic [EIDX_W-1:0]         out_element_index,
  input logic [LEN_W-1:0]          out_length,
  input logic                      out_last
);

  logic [ST_W+FIELD_W+EIDX_W+LEN_W:0] res_bits;  // whole result word
  logic                               held;      // result waiting on a stall
  logic                               err_res;   // result carries an error
  logic                               res_zero;  // data and index both zero

  assign res_bits = {out_status, out_data_out, out_element_index, out_length, out_last};
  assign held     = out_valid && out_stall;
  assign err_res  = out_valid && (out_status != ST_OK);
  assign res_zero = (out_data_out == '0) && (out_element_index == '0);

  // held result must not change
  `PLSC_ASSERT_NEXT(a_hold, held, out_valid && $stable(res_bits), "held result changed")

  // only a dump has more than one result, and dump results are ok
  `PLSC_ASSERT_NOW(a_err_last, err_res, out_last, "error result not final")

  `PLSC_ASSERT_NOW(a_err_zero, err_res, res_zero, "error result carries data")

  // mid-dump, no new request may enter
  `PLSC_ASSERT_NOW(a_dump_busy, out_valid && !out_last, in_stall, "request taken during dump")

  `PLSC_ASSERT_NOW(a_len_cap, out_valid, int'(out_length) <= CAPACITY, "length above capacity")

endmodule

bind positional_list_store_core plsc_chk u_plsc_chk (.*);
